>>> hdl/tld_pkg.sv
// tld_pkg: shared types, codes and constants of the tty line discipline
// no dependencies; imported by tty_line_discipline and the testbench
package tld_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int LINE_MAX_DEF   = 256;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_CANONICAL  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ECHO       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNAL     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CR_TO_NL   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NL_TO_CRNL = 3'd4;

  localparam logic [2:0] REQ_RX      = 3'd0;
  localparam logic [2:0] REQ_BREAK   = 3'd1;
  localparam logic [2:0] REQ_READ    = 3'd2;
  localparam logic [2:0] REQ_TX      = 3'd3;
  localparam logic [2:0] REQ_SERVICE = 3'd4;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [7:0] CH_NL  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       last;
    logic       do_attention;
    logic       do_interrupt;
    logic       do_poll_wake;
    logic [8:0] ring_fill;
  } out_t;

endpackage

>>> hdl/tld_ram.sv
// tld_ram: generic single-write, single-read ram with registered read data
// no dependencies
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/tty_line_discipline.sv
// tty_line_discipline: console line discipline, one transaction at a time under a sequencer
// uses tld_pkg and two tld_ram instances (read ring, line store)
// results: each passes ST_EMIT and the output register; a read with data first passes ST_RDATA,
// and a canonical newline first copies the line through the line store in ST_COPY and ST_NLPUSH
// flow: in_ready only in idle, so requests go one at a time; output stalls hold ST_EMIT
// reset: control state and flags clear at once; ram contents are not cleared
module tty_line_discipline
  #(
  parameter int RING_DEPTH = tld_pkg::RING_DEPTH_DEF,
  parameter int LINE_MAX   = tld_pkg::LINE_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tld_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tld_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [tld_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tld_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tld_pkg::*;

  localparam int RA = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int LA = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int LW = $clog2(LINE_MAX + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_COPY   = 3'd1;
  localparam logic [2:0] ST_NLPUSH = 3'd2;
  localparam logic [2:0] ST_RDATA  = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]    state;
  logic          canonical_mode, echo_enable, signal_enable, cr_to_nl, nl_to_crnl;
  logic [RA-1:0] ring_head, ring_tail;
  logic [CW-1:0] ring_count;
  logic [LW-1:0] line_length;
  logic [LW-1:0] copy_idx;
  logic          copy_pend;
  logic          interrupt_pending, attention_pending, wake_pending;
  logic          st_att, st_int, st_poll;
  logic [7:0]    ebuf [3];
  logic [1:0]    ecnt, eidx;
  logic [1:0]    cur_kind;

  logic          accept, out_free, emit;
  logic [7:0]    rx_b, stage_src;
  logic          is_sig, is_erase, is_nl, line_room, ring_nonempty;
  logic [7:0]    stage_b0, stage_b1;
  logic [1:0]    stage_cnt;
  logic          push_en, ring_wr, ring_take;
  logic [7:0]    push_byte;
  logic          line_we, line_re;
  logic [7:0]    line_rdata, ring_rdata;
  logic          copy_more;

  assign in_ready      = (state == ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign out_free      = !out_valid || out_ready;
  assign emit          = (state == ST_EMIT) && out_free;
  assign rx_b          = (in_data.data_byte == CH_CR && cr_to_nl) ? CH_NL : in_data.data_byte;
  assign is_sig        = (rx_b == CH_ETX) && signal_enable;
  assign is_erase      = (rx_b == CH_DEL) || (rx_b == CH_BS);
  assign is_nl         = (rx_b == CH_NL);
  assign line_room     = line_length < LW'(LINE_MAX);
  assign ring_nonempty = ring_count != '0;
  assign stage_src     = (in_data.req_type == REQ_TX) ? in_data.data_byte : rx_b;
  assign copy_more     = copy_idx < line_length;

  // nl expansion for echo and transmit
  always_comb begin
    if (stage_src == CH_NL && nl_to_crnl) begin
      stage_b0  = CH_CR;
      stage_b1  = CH_NL;
      stage_cnt = 2'd2;
    end else begin
      stage_b0  = stage_src;
      stage_b1  = 8'h00;
      stage_cnt = 2'd1;
    end
  end

  always_comb begin
    push_en   = 1'b0;
    push_byte = 8'h00;
    case (state)
      ST_IDLE: begin
        if (accept && in_data.req_type == REQ_RX && !is_sig && !canonical_mode) begin
          push_en   = 1'b1;
          push_byte = rx_b;
        end
      end
      ST_COPY: begin
        push_en   = copy_pend;
        push_byte = line_rdata;
      end
      ST_NLPUSH: begin
        push_en   = 1'b1;
        push_byte = CH_NL;
      end
      default: begin
        push_en   = 1'b0;
        push_byte = 8'h00;
      end
    endcase
  end

  assign ring_wr   = push_en && (ring_count < CW'(RING_DEPTH));
  assign ring_take = accept && in_data.req_type == REQ_READ && ring_nonempty;
  assign line_we   = accept && in_data.req_type == REQ_RX && !is_sig && canonical_mode
                     && !is_erase && !is_nl && line_room;
  assign line_re   = (state == ST_COPY) && copy_more;

  tld_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_wr),
    .waddr (ring_tail),
    .wdata (push_byte),
    .re    (ring_take),
    .raddr (ring_head),
    .rdata (ring_rdata)
  );

  tld_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_length[LA-1:0]),
    .wdata (rx_b),
    .re    (line_re),
    .raddr (copy_idx[LA-1:0]),
    .rdata (line_rdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      canonical_mode <= 1'b0;
      echo_enable    <= 1'b0;
      signal_enable  <= 1'b1;
      cr_to_nl       <= 1'b0;
      nl_to_crnl     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CANONICAL:  canonical_mode <= cfg_data[0];
        CFG_ECHO:       echo_enable    <= cfg_data[0];
        CFG_SIGNAL:     signal_enable  <= cfg_data[0];
        CFG_CR_TO_NL:   cr_to_nl       <= cfg_data[0];
        CFG_NL_TO_CRNL: nl_to_crnl     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // ring pointers and pending flags
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head         <= '0;
      ring_tail         <= '0;
      ring_count        <= '0;
      interrupt_pending <= 1'b0;
      attention_pending <= 1'b0;
      wake_pending      <= 1'b0;
    end else begin
      if (ring_wr) begin
        ring_tail  <= (ring_tail == RA'(RING_DEPTH - 1)) ? '0 : ring_tail + 1'b1;
        ring_count <= ring_count + 1'b1;
        if (!ring_nonempty) begin
          wake_pending <= 1'b1;
        end
      end else if (ring_take) begin
        ring_head  <= (ring_head == RA'(RING_DEPTH - 1)) ? '0 : ring_head + 1'b1;
        ring_count <= ring_count - 1'b1;
      end
      if (accept && in_data.req_type == REQ_RX && is_sig) begin
        interrupt_pending <= 1'b1;
      end
      if (accept && in_data.req_type == REQ_BREAK) begin
        attention_pending <= 1'b1;
      end
      if (accept && in_data.req_type == REQ_SERVICE) begin
        interrupt_pending <= 1'b0;
        attention_pending <= 1'b0;
        wake_pending      <= 1'b0;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      line_length <= '0;
      copy_idx    <= '0;
      copy_pend   <= 1'b0;
      ecnt        <= '0;
      eidx        <= '0;
      cur_kind    <= KIND_TX;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            eidx     <= '0;
            cur_kind <= KIND_TX;
            ebuf[0]  <= stage_b0;
            ebuf[1]  <= stage_b1;
            ebuf[2]  <= 8'h00;
            ecnt     <= stage_cnt;
            case (in_data.req_type)
              REQ_RX: begin
                if (is_sig) begin
                  state <= ST_IDLE;
                end else if (canonical_mode) begin
                  if (is_erase) begin
                    if (line_length != '0) begin
                      line_length <= line_length - 1'b1;
                      ebuf[0] <= CH_BS;
                      ebuf[1] <= CH_SP;
                      ebuf[2] <= CH_BS;
                      ecnt    <= 2'd3;
                      state   <= echo_enable ? ST_EMIT : ST_IDLE;
                    end
                  end else if (is_nl) begin
                    copy_idx  <= '0;
                    copy_pend <= 1'b0;
                    ecnt      <= echo_enable ? stage_cnt : 2'd0;
                    state     <= ST_COPY;
                  end else if (line_room) begin
                    line_length <= line_length + 1'b1;
                    state       <= echo_enable ? ST_EMIT : ST_IDLE;
                  end
                end else begin
                  state <= echo_enable ? ST_EMIT : ST_IDLE;
                end
              end
              REQ_READ: begin
                ebuf[0]  <= 8'h00;
                ecnt     <= 2'd1;
                cur_kind <= KIND_EMPTY;
                state    <= ring_nonempty ? ST_RDATA : ST_EMIT;
              end
              REQ_TX: begin
                state <= ST_EMIT;
              end
              REQ_SERVICE: begin
                st_att   <= attention_pending;
                st_int   <= interrupt_pending && !attention_pending;
                st_poll  <= wake_pending;
                ebuf[0]  <= 8'h00;
                ecnt     <= 2'd1;
                cur_kind <= KIND_STATUS;
                state    <= ST_EMIT;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_COPY: begin
          if (copy_more) begin
            copy_idx  <= copy_idx + 1'b1;
            copy_pend <= 1'b1;
          end else begin
            copy_pend <= 1'b0;
            if (!copy_pend) begin
              state <= ST_NLPUSH;
            end
          end
        end
        ST_NLPUSH: begin
          line_length <= '0;
          state       <= (ecnt != '0) ? ST_EMIT : ST_IDLE;
        end
        ST_RDATA: begin
          ebuf[0]  <= ring_rdata;
          cur_kind <= KIND_READ;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            eidx <= eidx + 1'b1;
            if (eidx == ecnt - 1'b1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.out_kind     <= cur_kind;
      out_data.out_byte     <= ebuf[eidx];
      out_data.last         <= (eidx == ecnt - 1'b1);
      out_data.do_attention <= (cur_kind == KIND_STATUS) && st_att;
      out_data.do_interrupt <= (cur_kind == KIND_STATUS) && st_int;
      out_data.do_poll_wake <= (cur_kind == KIND_STATUS) && st_poll;
      out_data.ring_fill    <= 9'(ring_count);
    end
  end

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= CW'(RING_DEPTH))
    else $error("ring count beyond depth");

  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LW'(LINE_MAX))
    else $error("line length beyond maximum");

  a_wake_on_push: assert property (@(posedge clk) disable iff (rst)
    ring_wr && !ring_nonempty |=> wake_pending)
    else $error("push into empty ring did not set wake flag");

  a_service_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.req_type == REQ_SERVICE |=>
      state == ST_EMIT && !interrupt_pending && !attention_pending && !wake_pending)
    else $error("service did not clear pending flags");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_kind != KIND_STATUS |->
      !out_data.do_attention && !out_data.do_interrupt && !out_data.do_poll_wake)
    else $error("status bits on a non-status result");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ring_wr |=> ring_count == $past(ring_count) + 1'b1)
    else $error("ring count did not follow a push");

endmodule

>>> tb/tb_tty_line_discipline.sv
// tb_tty_line_discipline: self-checking testbench for the tty line discipline
// depends on tld_pkg and tty_line_discipline; a scoreboard class predicts every result
// directed cases, line and ring fill to their limits, then random phases per setting
module tb_tty_line_discipline;
  timeunit 1ns;
  timeprecision 1ps;

  import tld_pkg::*;

  class tld_scoreboard;
    logic [7:0]  ring_mem [RING_DEPTH_DEF];
    int unsigned ring_head;
    int unsigned ring_tail;
    int unsigned ring_count;
    logic [7:0]  line_mem [LINE_MAX_DEF];
    int unsigned line_cnt;
    bit          intr_pend;
    bit          attn_pend;
    bit          wake_pend;
    bit          canon;
    bit          echo;
    bit          sig;
    bit          crnl;
    bit          nlx;
    logic [7:0]  echo_bytes [$];
    out_t        exp_q [$];
    int          errors;

    function new();
      ring_head  = 0;
      ring_tail  = 0;
      ring_count = 0;
      line_cnt   = 0;
      intr_pend  = 1'b0;
      attn_pend  = 1'b0;
      wake_pend  = 1'b0;
      canon      = 1'b0;
      echo       = 1'b0;
      sig        = 1'b1;
      crnl       = 1'b0;
      nlx        = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic v);
      case (idx)
        CFG_CANONICAL:  canon = v;
        CFG_ECHO:       echo  = v;
        CFG_SIGNAL:     sig   = v;
        CFG_CR_TO_NL:   crnl  = v;
        CFG_NL_TO_CRNL: nlx   = v;
        default: ;
      endcase
    endfunction

    function void push_ring(logic [7:0] b);
      if (ring_count >= RING_DEPTH_DEF) return;
      ring_mem[ring_tail] = b;
      ring_tail = (ring_tail + 1) % RING_DEPTH_DEF;
      if (ring_count == 0) wake_pend = 1'b1;
      ring_count++;
    endfunction

    function void stage(logic [7:0] b);
      if (b == CH_NL && nlx) begin
        echo_bytes.push_back(CH_CR);
        echo_bytes.push_back(CH_NL);
      end else begin
        echo_bytes.push_back(b);
      end
    endfunction

    function void rx_byte(logic [7:0] raw);
      logic [7:0] b;
      b = (raw == CH_CR && crnl) ? CH_NL : raw;
      if (b == CH_ETX && sig) begin
        intr_pend = 1'b1;
      end else if (canon) begin
        if (b == CH_DEL || b == CH_BS) begin
          if (line_cnt > 0) begin
            line_cnt--;
            if (echo) begin
              echo_bytes.push_back(CH_BS);
              echo_bytes.push_back(CH_SP);
              echo_bytes.push_back(CH_BS);
            end
          end
        end else if (b == CH_NL) begin
          for (int i = 0; i < line_cnt; i++) push_ring(line_mem[i]);
          push_ring(CH_NL);
          line_cnt = 0;
          if (echo) stage(b);
        end else if (line_cnt < LINE_MAX_DEF) begin
          line_mem[line_cnt] = b;
          line_cnt++;
          if (echo) stage(b);
        end
      end else begin
        push_ring(b);
        if (echo) stage(b);
      end
    endfunction

    function void note_input(in_t it);
      out_t r;
      echo_bytes.delete();
      r = '0;
      case (it.req_type)
        REQ_RX:    rx_byte(it.data_byte);
        REQ_BREAK: attn_pend = 1'b1;
        REQ_READ: begin
          if (ring_count > 0) begin
            r.out_kind = KIND_READ;
            r.out_byte = ring_mem[ring_head];
            ring_head = (ring_head + 1) % RING_DEPTH_DEF;
            ring_count--;
          end else begin
            r.out_kind = KIND_EMPTY;
          end
          r.last = 1'b1;
          r.ring_fill = 9'(ring_count);
          exp_q.push_back(r);
        end
        REQ_TX:    stage(it.data_byte);
        REQ_SERVICE: begin
          r.out_kind = KIND_STATUS;
          r.do_attention = attn_pend;
          r.do_interrupt = intr_pend && !attn_pend;
          r.do_poll_wake = wake_pend;
          r.last = 1'b1;
          r.ring_fill = 9'(ring_count);
          exp_q.push_back(r);
          intr_pend = 1'b0;
          attn_pend = 1'b0;
          wake_pend = 1'b0;
        end
        default: ;
      endcase
      for (int k = 0; k < echo_bytes.size(); k++) begin
        r = '0;
        r.out_kind = KIND_TX;
        r.out_byte = echo_bytes[k];
        r.last = (k == echo_bytes.size() - 1);
        r.ring_fill = 9'(ring_count);
        exp_q.push_back(r);
      end
    endfunction

    function void note_error(string msg);
      if (errors < 10) $display("%s", msg);
      errors++;
    endfunction

    function string fmt_result(string tag, out_t r);
      return $sformatf("%s kind=%0d byte=%02h last=%b att=%b int=%b wake=%b fill=%0d",
                       tag, r.out_kind, r.out_byte, r.last, r.do_attention,
                       r.do_interrupt, r.do_poll_wake, r.ring_fill);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (exp_q.size() == 0) begin
        note_error({"unexpected result: ", fmt_result("actual", got)});
        return;
      end
      want = exp_q.pop_front();
      if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
          got.last !== want.last || got.do_attention !== want.do_attention ||
          got.do_interrupt !== want.do_interrupt ||
          got.do_poll_wake !== want.do_poll_wake || got.ring_fill !== want.ring_fill)
        note_error({"mismatch: ", fmt_result("expected", want), " / ",
                    fmt_result("actual", got)});
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_t                    in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_t                   out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  tld_scoreboard sb = new();

  tty_line_discipline u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_tty_line_discipline: FAIL");
    $finish;
  end

  // receiver with random stall bursts and one long hold-off on request
  initial begin
    int stall_left;
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 600;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  task automatic send_request(input logic [2:0] req, input logic [7:0] b);
    in_t item;
    int  gap;
    item.req_type  = req;
    item.data_byte = b;
    gap = 0;
    if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 18);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(item);
  endtask

  // no result marks the end of a break or silent newline, so allow the full latency
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.write_reg(idx, v);
  endtask

  task automatic write_cfg(input bit canon_on, input bit echo_on, input bit sig_on,
                           input bit crnl_on, input bit nlx_on);
    cfg_write(CFG_CANONICAL, canon_on);
    cfg_write(CFG_ECHO, echo_on);
    cfg_write(CFG_SIGNAL, sig_on);
    cfg_write(CFG_CR_TO_NL, crnl_on);
    cfg_write(CFG_NL_TO_CRNL, nlx_on);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [2:0] req;
    logic [7:0] b;
    logic [4:0] cfg_bits;
    int         sel;
    int         count;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: raw, no echo, signal on
    send_request(REQ_READ, 8'($urandom));
    send_request(REQ_RX, 8'h00);
    send_request(REQ_RX, 8'hff);
    send_request(REQ_RX, CH_ETX);
    send_request(REQ_RX, CH_CR);
    send_request(REQ_BREAK, 8'($urandom));
    send_request(REQ_SERVICE, 8'($urandom));
    send_request(REQ_SERVICE, 8'($urandom));
    repeat (3) send_request(REQ_READ, 8'($urandom));
    send_request(REQ_TX, CH_NL);
    send_request(REQ_TX, 8'hff);
    for (int k = 1; k <= 3; k++) send_request(REQ_SERVICE + 3'(k), 8'($urandom));

    wait_quiet();
    write_cfg(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_request(REQ_RX, 8'h61);
    send_request(REQ_RX, CH_DEL);
    send_request(REQ_RX, CH_BS);
    send_request(REQ_RX, CH_ETX);
    send_request(REQ_RX, 8'h7e);
    send_request(REQ_RX, CH_CR);
    send_request(REQ_SERVICE, 8'($urandom));
    repeat (2) send_request(REQ_READ, 8'($urandom));
    send_request(REQ_TX, CH_NL);

    // overfill the line, then the ring, then a raw push into the full ring
    wait_quiet();
    write_cfg(1'b1, 1'b1, 1'b0, 1'b0, 1'($urandom));
    send_request(REQ_RX, CH_NL);
    while (sb.ring_count > 0) send_request(REQ_READ, 8'($urandom));
    repeat (LINE_MAX_DEF + 2) begin
      do b = 8'($urandom); while (b == CH_NL || b == CH_BS || b == CH_DEL);
      send_request(REQ_RX, b);
    end
    send_request(REQ_RX, CH_NL);
    wait_quiet();
    write_cfg(1'b0, 1'b1, 1'b0, 1'b0, 1'($urandom));
    send_request(REQ_RX, 8'($urandom));
    repeat (2) send_request(REQ_READ, 8'($urandom));

    for (int p = 0; p < 8; p++) begin
      if (p == 0) cfg_bits = '0;
      else if (p == 1) cfg_bits = '1;
      else cfg_bits = 5'($urandom);
      wait_quiet();
      write_cfg(cfg_bits[0], cfg_bits[1], cfg_bits[2], cfg_bits[3], cfg_bits[4]);
      idle_on = (p < 7) && ($urandom_range(0, 3) != 0);
      count = 0;
      while (count < 4) begin
        if (p == 2 && count == 2) hold_req = 1'b1;
        sel = $urandom_range(0, 99);
        b = 8'($urandom);
        if (sel < 45) begin
          req = REQ_RX;
          sel = $urandom_range(0, 9);
          if (sel < 5) begin
            b = 8'($urandom_range(32, 126));
          end else if (sel >= 7) begin
            case ($urandom_range(0, 4))
              0: b = CH_NL;
              1: b = CH_CR;
              2: b = CH_BS;
              3: b = CH_DEL;
              default: b = CH_ETX;
            endcase
          end
        end else if (sel < 67) begin
          req = REQ_READ;
        end else if (sel < 79) begin
          req = REQ_TX;
          if ($urandom_range(0, 3) == 0) b = CH_NL;
        end else if (sel < 87) begin
          req = REQ_SERVICE;
        end else if (sel < 92) begin
          req = REQ_BREAK;
        end else begin
          req = REQ_SERVICE + 3'($urandom_range(1, 3));
        end
        // a result during the hold-off fills the output and stalls the input
        if (p == 2 && count == 2) req = REQ_TX;
        send_request(req, b);
        if (req <= REQ_SERVICE) count++;
      end
    end

    wait_quiet();
    if (sb.errors == 0) begin
      $display("tb_tty_line_discipline: PASS");
    end else begin
      $display("tb_tty_line_discipline: FAIL");
    end
    $finish;
  end
endmodule

>>> tty_line_discipline.f
hdl/tld_pkg.sv
hdl/tld_ram.sv
hdl/tty_line_discipline.sv
tb/tb_tty_line_discipline.sv
